>>> src/bvsh_pkg.sv
// ----------------------------------------------------------------------------
// bvsh_pkg
// Shared constants for the box versus swept-box hull test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bvsh_pkg;

    // default coordinate width, signed fixed point
    localparam int BVSH_COORD_BITS = 24;

endpackage : bvsh_pkg

`default_nettype wire

>>> src/bvsh_if.sv
// ----------------------------------------------------------------------------
// bvsh_if
// Valid/ready channels: box word in (tile and two stroke boxes), hit word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvsh_box_if
    import bvsh_pkg::*;
#(
    parameter int W = BVSH_COORD_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] tile_x_low;
    logic signed [W-1:0] tile_x_high;
    logic signed [W-1:0] tile_y_low;
    logic signed [W-1:0] tile_y_high;
    logic signed [W-1:0] first_x_low;
    logic signed [W-1:0] first_x_high;
    logic signed [W-1:0] first_y_low;
    logic signed [W-1:0] first_y_high;
    logic signed [W-1:0] second_x_low;
    logic signed [W-1:0] second_x_high;
    logic signed [W-1:0] second_y_low;
    logic signed [W-1:0] second_y_high;

    modport source (
        output valid,
        output tile_x_low, tile_x_high, tile_y_low, tile_y_high,
        output first_x_low, first_x_high, first_y_low, first_y_high,
        output second_x_low, second_x_high, second_y_low, second_y_high,
        input  ready
    );

    modport sink (
        input  valid,
        input  tile_x_low, tile_x_high, tile_y_low, tile_y_high,
        input  first_x_low, first_x_high, first_y_low, first_y_high,
        input  second_x_low, second_x_high, second_y_low, second_y_high,
        output ready
    );
endinterface : bvsh_box_if

interface bvsh_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid,
        output hit,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit,
        output ready
    );
endinterface : bvsh_hit_if

`default_nettype wire

>>> src/box_vs_swept_box_hull_test_unit.sv
// ----------------------------------------------------------------------------
// box_vs_swept_box_hull_test_unit
// Tells whether a tile box overlaps the convex hull of two stroke boxes.
// ----------------------------------------------------------------------------
//  channel | dir | word                                   | handshake
//  i_box   | in  | tile, first and second box bounds      | valid/ready
//  o_hit   | out | hit flag                               | valid/ready
//
//  One word per cycle sustained while o_hit.ready holds; an accepted word reaches
//  o_hit.valid over five register stages (input register, select, subtract,
//  multiply, compare/output).
//  The multiply stage (eight COORD_BITS+1 square products) sets the depth.
//  Reset (synchronous, active low) clears the stage valid bits only.
//  Each stage holds while the next one is full and stalled; bubbles close up,
//  so a word is taken while a finished result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module box_vs_swept_box_hull_test_unit
    import bvsh_pkg::*;
#(
    parameter int COORD_BITS = BVSH_COORD_BITS
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    bvsh_box_if.sink      i_box,
    bvsh_hit_if.source    o_hit
);

    localparam int DW = COORD_BITS + 1;     // exact difference / centre sum
    localparam int PW = 2 * DW;             // exact product

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic signed [PW-1:0]         t_prod;

    typedef struct packed {
        t_coord xl;
        t_coord xh;
        t_coord yl;
        t_coord yh;
    } t_box;

    // centre order: {second x greater, second y greater}
    typedef enum logic [1:0] {
        QUAD_NONE = 2'b00,
        QUAD_Y    = 2'b01,
        QUAD_X    = 2'b10,
        QUAD_XY   = 2'b11
    } t_quad;

    function automatic logic overlap(input t_box a, input t_box b);
        return ($signed(a.xh) >= $signed(b.xl)) && ($signed(a.xl) <= $signed(b.xh))
            && ($signed(a.yh) >= $signed(b.yl)) && ($signed(a.yl) <= $signed(b.yh));
    endfunction

    // ------------------------------------------------------------------
    // stage enables
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || o_hit.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_box.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_box.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    t_box r_tile1, r_p1, r_q1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_tile1 <= '{xl: i_box.tile_x_low,    xh: i_box.tile_x_high,
                         yl: i_box.tile_y_low,    yh: i_box.tile_y_high};
            r_p1    <= '{xl: i_box.first_x_low,   xh: i_box.first_x_high,
                         yl: i_box.first_y_low,   yh: i_box.first_y_high};
            r_q1    <= '{xl: i_box.second_x_low,  xh: i_box.second_x_high,
                         yl: i_box.second_y_low,  yh: i_box.second_y_high};
        end
    end

    // ------------------------------------------------------------------
    // stage 2: box tests, quadrant case, edge anchor/end selection
    // ------------------------------------------------------------------
    t_box   u_box;
    logic   n_direct, n_umiss;
    t_diff  cpx, cpy, cqx, cqy;
    t_quad  quad;
    t_coord n_ax [2];
    t_coord n_ay [2];
    t_coord n_ex [2];
    t_coord n_ey [2];

    always_comb begin
        n_direct = overlap(r_tile1, r_p1) || overlap(r_tile1, r_q1);

        u_box.xl = ($signed(r_p1.xl) < $signed(r_q1.xl)) ? r_p1.xl : r_q1.xl;
        u_box.yl = ($signed(r_p1.yl) < $signed(r_q1.yl)) ? r_p1.yl : r_q1.yl;
        u_box.xh = ($signed(r_p1.xh) > $signed(r_q1.xh)) ? r_p1.xh : r_q1.xh;
        u_box.yh = ($signed(r_p1.yh) > $signed(r_q1.yh)) ? r_p1.yh : r_q1.yh;
        n_umiss  = !overlap(r_tile1, u_box);

        // centres compared as low + high, no halving needed
        cpx  = t_diff'($signed(r_p1.xl)) + t_diff'($signed(r_p1.xh));
        cpy  = t_diff'($signed(r_p1.yl)) + t_diff'($signed(r_p1.yh));
        cqx  = t_diff'($signed(r_q1.xl)) + t_diff'($signed(r_q1.xh));
        cqy  = t_diff'($signed(r_q1.yl)) + t_diff'($signed(r_q1.yh));
        quad = t_quad'({cqx > cpx, cqy > cpy});

        // edge vector is end - anchor
        case (quad)
            QUAD_XY: begin
                n_ax[0] = r_p1.xh; n_ay[0] = r_p1.yl; n_ex[0] = r_q1.xh; n_ey[0] = r_q1.yl;
                n_ax[1] = r_q1.xl; n_ay[1] = r_q1.yh; n_ex[1] = r_p1.xl; n_ey[1] = r_p1.yh;
            end
            QUAD_X: begin
                n_ax[0] = r_q1.xh; n_ay[0] = r_q1.yh; n_ex[0] = r_p1.xh; n_ey[0] = r_p1.yh;
                n_ax[1] = r_p1.xl; n_ay[1] = r_p1.yl; n_ex[1] = r_q1.xl; n_ey[1] = r_q1.yl;
            end
            QUAD_Y: begin
                n_ax[0] = r_p1.xh; n_ay[0] = r_p1.yh; n_ex[0] = r_q1.xh; n_ey[0] = r_q1.yh;
                n_ax[1] = r_q1.xl; n_ay[1] = r_q1.yl; n_ex[1] = r_p1.xl; n_ey[1] = r_p1.yl;
            end
            default: begin
                n_ax[0] = r_q1.xh; n_ay[0] = r_q1.yl; n_ex[0] = r_p1.xh; n_ey[0] = r_p1.yl;
                n_ax[1] = r_p1.xl; n_ay[1] = r_p1.yh; n_ex[1] = r_q1.xl; n_ey[1] = r_q1.yh;
            end
        endcase
    end

    t_box   r_tile2;
    logic   r_direct2, r_umiss2;
    t_coord r_ax2 [2];
    t_coord r_ay2 [2];
    t_coord r_ex2 [2];
    t_coord r_ey2 [2];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_tile2   <= r_tile1;
            r_direct2 <= n_direct;
            r_umiss2  <= n_umiss;
            r_ax2     <= n_ax;
            r_ay2     <= n_ay;
            r_ex2     <= n_ex;
            r_ey2     <= n_ey;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: edge vectors and corner offsets from the anchors
    // ------------------------------------------------------------------
    logic  r_direct3, r_umiss3;
    t_diff r_lx3 [2];
    t_diff r_ly3 [2];
    t_diff r_dx3 [2][2];    // [edge][x low/high]
    t_diff r_dy3 [2][2];    // [edge][y low/high]

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_direct3 <= r_direct2;
            r_umiss3  <= r_umiss2;
            for (int e = 0; e < 2; e++) begin
                r_lx3[e]    <= t_diff'($signed(r_ex2[e])) - t_diff'($signed(r_ax2[e]));
                r_ly3[e]    <= t_diff'($signed(r_ey2[e])) - t_diff'($signed(r_ay2[e]));
                r_dx3[e][0] <= t_diff'($signed(r_tile2.xl)) - t_diff'($signed(r_ax2[e]));
                r_dx3[e][1] <= t_diff'($signed(r_tile2.xh)) - t_diff'($signed(r_ax2[e]));
                r_dy3[e][0] <= t_diff'($signed(r_tile2.yl)) - t_diff'($signed(r_ay2[e]));
                r_dy3[e][1] <= t_diff'($signed(r_tile2.yh)) - t_diff'($signed(r_ay2[e]));
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: cross product terms, shared across the four corners
    // ------------------------------------------------------------------
    logic  r_direct4, r_umiss4;
    t_prod r_pa4 [2][2];    // lx * dy[y]
    t_prod r_pb4 [2][2];    // ly * dx[x]

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_direct4 <= r_direct3;
            r_umiss4  <= r_umiss3;
            for (int e = 0; e < 2; e++) begin
                for (int k = 0; k < 2; k++) begin
                    r_pa4[e][k] <= r_lx3[e] * r_dy3[e][k];
                    r_pb4[e][k] <= r_ly3[e] * r_dx3[e][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: strict right-side test on all corners, output register
    // ------------------------------------------------------------------
    logic [1:0] edge_hit;
    logic       n_hit;
    logic       r_hit5;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            edge_hit[e] = 1'b1;
            for (int xi = 0; xi < 2; xi++) begin
                for (int yi = 0; yi < 2; yi++) begin
                    if (!(r_pa4[e][yi] < r_pb4[e][xi])) edge_hit[e] = 1'b0;
                end
            end
        end
        n_hit = r_direct4 || (!r_umiss4 && (|edge_hit));
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_hit5 <= n_hit;
        end
    end

    assign o_hit.valid = r_v5;
    assign o_hit.hit   = r_hit5;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_direct_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5 && r_direct4) |=> (o_hit.valid && o_hit.hit))
        else $error("direct box overlap did not give a hit");

    a_union_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5 && r_umiss4 && !r_direct4) |=> (o_hit.valid && !o_hit.hit))
        else $error("union box miss gave a hit");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready) |=> r_v1)
        else $error("accepted word not held in input stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !en5) |=> (r_v4 && $stable(r_direct4) && $stable(r_umiss4)))
        else $error("product stage changed while stalled");

endmodule : box_vs_swept_box_hull_test_unit

`default_nettype wire

>>> bench/box_vs_swept_box_hull_test_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_vs_swept_box_hull_test_unit_tb
// Drives box words (tile plus two stroke boxes) through the hull test unit and
// checks every hit flag against an exact integer predictor kept in a small
// scoreboard. Directed corner cases come first, then random words: mostly
// stroke pairs with a tile placed inside their union box, plus raw noise and
// inverted boxes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module box_vs_swept_box_hull_test_unit_tb;
    import bvsh_pkg::*;

    localparam int     CW           = BVSH_COORD_BITS;
    localparam longint COORD_MIN    = -(longint'(1) <<< (CW - 1));
    localparam longint COORD_MAX    = (longint'(1) <<< (CW - 1)) - 1;
    localparam int     RANDOM_WORDS = 680;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [CW-1:0] tile_xl, tile_xh, tile_yl, tile_yh;
        logic signed [CW-1:0] first_xl, first_xh, first_yl, first_yh;
        logic signed [CW-1:0] second_xl, second_xh, second_yl, second_yh;
    } t_box_word;

    typedef struct {
        longint xl, xh, yl, yh;
    } t_rect;

    class hit_scoreboard;
        bit hit_expected[$];
        int words_noted;
        int flags_checked;
        int hits_seen;
        int edge_resolved;
        int mismatches;

        function new();
            words_noted   = 0;
            flags_checked = 0;
            hits_seen     = 0;
            edge_resolved = 0;
            mismatches    = 0;
        endfunction

        // inclusive overlap, bounds taken as given
        function bit rects_touch(t_rect a, t_rect b);
            return a.xh >= b.xl && a.xl <= b.xh && a.yh >= b.yl && a.yl <= b.yh;
        endfunction

        // all four tile corners strictly right of edge (lx,ly) anchored at (ax,ay)
        function bit edge_clears(t_rect t, longint lx, longint ly, longint ax, longint ay);
            longint cx[4];
            longint cy[4];
            cx = '{t.xl, t.xl, t.xh, t.xh};
            cy = '{t.yl, t.yh, t.yl, t.yh};
            foreach (cx[i])
                if (lx * (cy[i] - ay) >= ly * (cx[i] - ax)) return 1'b0;
            return 1'b1;
        endfunction

        function bit predict_hit(t_box_word w);
            t_rect  t, p, q, u;
            longint cpx, cpy, cqx, cqy;
            t.xl = w.tile_xl;   t.xh = w.tile_xh;   t.yl = w.tile_yl;   t.yh = w.tile_yh;
            p.xl = w.first_xl;  p.xh = w.first_xh;  p.yl = w.first_yl;  p.yh = w.first_yh;
            q.xl = w.second_xl; q.xh = w.second_xh; q.yl = w.second_yl; q.yh = w.second_yh;
            if (rects_touch(t, p) || rects_touch(t, q)) return 1'b1;
            u.xl = (p.xl < q.xl) ? p.xl : q.xl;
            u.yl = (p.yl < q.yl) ? p.yl : q.yl;
            u.xh = (p.xh > q.xh) ? p.xh : q.xh;
            u.yh = (p.yh > q.yh) ? p.yh : q.yh;
            if (!rects_touch(t, u)) return 1'b0;
            edge_resolved++;
            // centres compared as doubled sums; a tie means second not greater
            cpx = p.xl + p.xh;
            cpy = p.yl + p.yh;
            cqx = q.xl + q.xh;
            cqy = q.yl + q.yh;
            if (cqx > cpx) begin
                if (cqy > cpy)
                    return edge_clears(t, q.xh - p.xh, q.yl - p.yl, p.xh, p.yl)
                        || edge_clears(t, p.xl - q.xl, p.yh - q.yh, q.xl, q.yh);
                return edge_clears(t, p.xh - q.xh, p.yh - q.yh, q.xh, q.yh)
                    || edge_clears(t, q.xl - p.xl, q.yl - p.yl, p.xl, p.yl);
            end
            if (cqy > cpy)
                return edge_clears(t, q.xh - p.xh, q.yh - p.yh, p.xh, p.yh)
                    || edge_clears(t, p.xl - q.xl, p.yl - q.yl, q.xl, q.yl);
            return edge_clears(t, p.xh - q.xh, p.yl - q.yl, q.xh, q.yl)
                || edge_clears(t, q.xl - p.xl, q.yh - p.yh, p.xl, p.yh);
        endfunction

        function void note_box(t_box_word w);
            hit_expected = {hit_expected, predict_hit(w)};
            words_noted++;
        endfunction

        function int pending();
            return hit_expected.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        task check_hit(logic got);
            bit want;
            if (hit_expected.size() == 0) begin
                report_mismatch($sformatf("hit flag %b with no box word outstanding", got));
                return;
            end
            want = hit_expected.pop_front();
            flags_checked++;
            if (got === 1'b1) hits_seen++;
            if (got !== want)
                report_mismatch($sformatf("flag %0d: hit %b, expected %b",
                                          flags_checked - 1, got, want));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady_phase;
    int   cycle_count;

    hit_scoreboard sb;

    bvsh_box_if #(.W(CW)) box_ch ();
    bvsh_hit_if           hit_ch ();

    box_vs_swept_box_hull_test_unit #(
        .COORD_BITS(CW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch),
        .o_hit   (hit_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_rect mk(longint xl, longint xh, longint yl, longint yh);
        t_rect r;
        r.xl = xl;
        r.xh = xh;
        r.yl = yl;
        r.yh = yh;
        return r;
    endfunction

    function automatic t_box_word pack_word(t_rect t, t_rect p, t_rect q);
        t_box_word w;
        w.tile_xl   = CW'(t.xl); w.tile_xh   = CW'(t.xh);
        w.tile_yl   = CW'(t.yl); w.tile_yh   = CW'(t.yh);
        w.first_xl  = CW'(p.xl); w.first_xh  = CW'(p.xh);
        w.first_yl  = CW'(p.yl); w.first_yh  = CW'(p.yh);
        w.second_xl = CW'(q.xl); w.second_xh = CW'(q.xh);
        w.second_yl = CW'(q.yl); w.second_yh = CW'(q.yh);
        return w;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic longint span_draw(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic t_rect rand_rect(longint span);
        longint cx, cy, hx, hy;
        cx = span_draw(span);
        cy = span_draw(span);
        hx = longint'($urandom_range(0, 32'(span / 4)));
        hy = longint'($urandom_range(0, 32'(span / 4)));
        return mk(clamp_coord(cx - hx), clamp_coord(cx + hx),
                  clamp_coord(cy - hy), clamp_coord(cy + hy));
    endfunction

    function automatic t_box_word random_box_word();
        t_box_word w;
        t_rect     t, p, q;
        longint    span, uxl, uxh, uyl, uyh, px, py, tw, th, tmp;
        int        kind, scale, which;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // raw noise over the full field width
            w.tile_xl   = CW'($urandom); w.tile_xh   = CW'($urandom);
            w.tile_yl   = CW'($urandom); w.tile_yh   = CW'($urandom);
            w.first_xl  = CW'($urandom); w.first_xh  = CW'($urandom);
            w.first_yl  = CW'($urandom); w.first_yh  = CW'($urandom);
            w.second_xl = CW'($urandom); w.second_xh = CW'($urandom);
            w.second_yl = CW'($urandom); w.second_yh = CW'($urandom);
            return w;
        end
        scale = $urandom_range(0, 9);
        span  = (scale < 5) ? 64 : (scale < 8) ? 4096 : (scale < 9) ? (1 << 20) : (1 << 23);
        p     = rand_rect(span);
        q     = rand_rect(span);
        uxl   = (p.xl < q.xl) ? p.xl : q.xl;
        uxh   = (p.xh > q.xh) ? p.xh : q.xh;
        uyl   = (p.yl < q.yl) ? p.yl : q.yl;
        uyh   = (p.yh > q.yh) ? p.yh : q.yh;
        // tile anchored inside the union box, so most words reach the edge tests
        px    = uxl + longint'($urandom_range(0, 32'(uxh - uxl)));
        py    = uyl + longint'($urandom_range(0, 32'(uyh - uyl)));
        tw    = longint'($urandom_range(0, 32'(span / 8)));
        th    = longint'($urandom_range(0, 32'(span / 8)));
        t     = mk(px, clamp_coord(px + tw), py, clamp_coord(py + th));
        if (kind == 9) begin
            // broken word: one box inverted on one axis
            which = $urandom_range(0, 5);
            case (which)
                0: begin tmp = t.xl; t.xl = t.xh; t.xh = tmp; end
                1: begin tmp = t.yl; t.yl = t.yh; t.yh = tmp; end
                2: begin tmp = p.xl; p.xl = p.xh; p.xh = tmp; end
                3: begin tmp = p.yl; p.yl = p.yh; p.yh = tmp; end
                4: begin tmp = q.xl; q.xl = q.xh; q.xh = tmp; end
                default: begin tmp = q.yl; q.yl = q.yh; q.yh = tmp; end
            endcase
        end
        return pack_word(t, p, q);
    endfunction

    task automatic put_fields(input t_box_word w);
        box_ch.tile_x_low    <= w.tile_xl;
        box_ch.tile_x_high   <= w.tile_xh;
        box_ch.tile_y_low    <= w.tile_yl;
        box_ch.tile_y_high   <= w.tile_yh;
        box_ch.first_x_low   <= w.first_xl;
        box_ch.first_x_high  <= w.first_xh;
        box_ch.first_y_low   <= w.first_yl;
        box_ch.first_y_high  <= w.first_yh;
        box_ch.second_x_low  <= w.second_xl;
        box_ch.second_x_high <= w.second_xh;
        box_ch.second_y_low  <= w.second_yl;
        box_ch.second_y_high <= w.second_yh;
    endtask

    task automatic send_box(input t_box_word w);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_ch.valid <= 1'b1;
        put_fields(w);
        @(posedge i_clk);
        while (box_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_box(w);
    endtask

    task automatic hold_until_drained();
        box_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_directed();
        longint mn, mx;
        mn = COORD_MIN;
        mx = COORD_MAX;
        // field extremes
        send_box(pack_word(mk(mn, mn, mn, mn), mk(mn, mn, mn, mn), mk(mn, mn, mn, mn)));
        send_box(pack_word(mk(mx, mx, mx, mx), mk(mx, mx, mx, mx), mk(mx, mx, mx, mx)));
        send_box(pack_word(mk(mn, mx, mn, mx), mk(mn, mn + 9, mn, mn + 9),
                           mk(mx - 9, mx, mx - 9, mx)));
        send_box(pack_word(mk(-10, 10, -10, 10), mk(mn, mn + 1000, mn, mn + 1000),
                           mk(mx - 1000, mx, mx - 1000, mx)));
        send_box(pack_word(mk(mx - 500, mx - 400, mn, mn + 100),
                           mk(mn, mn + 1000, mn, mn + 1000), mk(mx - 1000, mx, mx - 1000, mx)));
        // touching at a corner and along an edge
        send_box(pack_word(mk(10, 20, 10, 20), mk(0, 10, 0, 10), mk(200, 210, 300, 310)));
        send_box(pack_word(mk(10, 20, 2, 5), mk(0, 10, 0, 10), mk(200, 210, 300, 310)));
        // the four centre orderings, a tile in the hull and one outside it
        send_box(pack_word(mk(50, 55, 50, 55), mk(0, 10, 0, 10), mk(100, 110, 100, 110)));
        send_box(pack_word(mk(90, 95, 5, 10), mk(0, 10, 0, 10), mk(100, 110, 100, 110)));
        send_box(pack_word(mk(50, 55, 50, 55), mk(0, 10, 100, 110), mk(100, 110, 0, 10)));
        send_box(pack_word(mk(5, 10, 5, 10), mk(0, 10, 100, 110), mk(100, 110, 0, 10)));
        send_box(pack_word(mk(50, 55, 50, 55), mk(100, 110, 0, 10), mk(0, 10, 100, 110)));
        send_box(pack_word(mk(95, 100, 95, 100), mk(100, 110, 0, 10), mk(0, 10, 100, 110)));
        send_box(pack_word(mk(50, 55, 50, 55), mk(100, 110, 100, 110), mk(0, 10, 0, 10)));
        send_box(pack_word(mk(5, 10, 95, 100), mk(100, 110, 100, 110), mk(0, 10, 0, 10)));
        // equal centres on both axes, then on one axis
        send_box(pack_word(mk(5, 10, 5, 10), mk(0, 100, 40, 60), mk(40, 60, 0, 100)));
        send_box(pack_word(mk(2, 4, 50, 52), mk(0, 10, 0, 10), mk(0, 10, 100, 110)));
        send_box(pack_word(mk(50, 52, 3, 5), mk(0, 10, 0, 10), mk(100, 110, 0, 10)));
        // zero-length hull edge
        send_box(pack_word(mk(5, 10, 50, 60), mk(0, 100, 0, 10), mk(50, 100, 0, 110)));
        // inverted tile, inverted strokes
        send_box(pack_word(mk(20, 10, 20, 10), mk(0, 10, 0, 10), mk(100, 110, 100, 110)));
        send_box(pack_word(mk(50, 55, 50, 55), mk(10, 0, 10, 0), mk(110, 100, 110, 100)));
        // outside the union box; exactly on a hull edge
        send_box(pack_word(mk(-50, -40, -50, -40), mk(0, 10, 0, 10), mk(100, 110, 100, 110)));
        send_box(pack_word(mk(100, 100, 90, 90), mk(0, 10, 0, 10), mk(100, 110, 100, 110)));
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("box_vs_swept_box_hull_test_unit verification failed");
        $finish;
    end

    initial begin : hit_drain
        int stall;
        hit_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = steady_phase ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                hit_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            hit_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (hit_ch.valid !== 1'b1) @(posedge i_clk);
            sb.check_hit(hit_ch.hit);
        end
    end

    initial begin : stimulus
        t_box_word blank;
        int        k;
        sb           = new();
        steady_phase = 1'b0;
        blank        = pack_word(mk(0, 0, 0, 0), mk(0, 0, 0, 0), mk(0, 0, 0, 0));
        i_rst_n      <= 1'b0;
        box_ch.valid <= 1'b0;
        put_fields(blank);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        hold_until_drained();

        for (k = 0; k < RANDOM_WORDS; k++) begin
            // now and then a stretch with no idling on either side
            if (k % 50 == 0) steady_phase = ($urandom_range(0, 3) == 0);
            if (k == RANDOM_WORDS / 2) hold_until_drained();
            send_box(random_box_word());
        end
        steady_phase = 1'b0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d box words sent, %0d hit flags checked, %0d of them hits",
                 sb.words_noted, sb.flags_checked, sb.hits_seen);
        $display("run: %0d words settled by the hull edge tests, %0d mismatches",
                 sb.edge_resolved, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("box_vs_swept_box_hull_test_unit verification clean");
        end else begin
            $display("box_vs_swept_box_hull_test_unit verification failed");
        end
        $finish;
    end

endmodule
